[hw/rtl/lfw_pkg.sv]
// ----------------------------------------------------------------------------
// lfw_pkg
// Shared widths, constants, action codes and types of the lagged Fibonacci
// generator with Weyl whitening.
// ----------------------------------------------------------------------------
`default_nettype none

package lfw_pkg;

	localparam int LONG_LAG  = 607;
	localparam int SHORT_LAG = 273;
	localparam int WORD_W    = 64;
	localparam int PTR_W     = 10;
	localparam int SLOT_W    = $clog2(LONG_LAG);

	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;

	typedef enum logic [1:0] {
		ACT_GEN  = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_WEYL = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		logic [SLOT_W-1:0] long_slot;
		logic [SLOT_W-1:0] short_slot;
		logic [WORD_W-1:0] weyl_next;
	} issue_t;

endpackage

`default_nettype wire

[hw/rtl/lfw_req_if.sv]
// ----------------------------------------------------------------------------
// lfw_req_if
// Request channel: action, ring position and load word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfw_req_if;
	import lfw_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [PTR_W-1:0]  entry_index;
	logic [WORD_W-1:0] load_value;

	modport source (output valid, output action, output entry_index, output load_value,
		input ready);
	modport sink (input valid, input action, input entry_index, input load_value,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/lfw_rsp_if.sv]
// ----------------------------------------------------------------------------
// lfw_rsp_if
// Result channel: one random word per generate request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfw_rsp_if;
	import lfw_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

[hw/rtl/lfw_ring.sv]
// ----------------------------------------------------------------------------
// lfw_ring
// Lag ring storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lfw_ring (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [lfw_pkg::SLOT_W-1:0] wr_slot,
	input  wire logic [lfw_pkg::WORD_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [lfw_pkg::SLOT_W-1:0] rd_a_slot,
	input  wire logic [lfw_pkg::SLOT_W-1:0] rd_b_slot,
	output logic      [lfw_pkg::WORD_W-1:0] rd_a_data,
	output logic      [lfw_pkg::WORD_W-1:0] rd_b_data
);
	import lfw_pkg::*;

	logic [WORD_W-1:0] mem [LONG_LAG];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_data <= mem[rd_a_slot];
			rd_b_data <= mem[rd_b_slot];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lfw_ptr.sv]
// ----------------------------------------------------------------------------
// lfw_ptr
// Long and short ring pointers and the Weyl counter; issues read slots.
// ----------------------------------------------------------------------------
`default_nettype none

module lfw_ptr (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic [1:0]                 action,
	input  wire logic [lfw_pkg::WORD_W-1:0] load_value,
	output lfw_pkg::issue_t                 issue
);
	import lfw_pkg::*;

	logic [PTR_W-1:0]  long_q;
	logic [PTR_W-1:0]  short_q;
	logic [WORD_W-1:0] weyl_q;
	logic [PTR_W-1:0]  long_dn;
	logic [PTR_W-1:0]  short_dn;
	action_t           act;

	assign act = action_t'(action);

	always_comb begin
		long_dn  = (long_q == PTR_W'(1)) ? PTR_W'(LONG_LAG) : long_q - PTR_W'(1);
		short_dn = (short_q == PTR_W'(1)) ? PTR_W'(LONG_LAG) : short_q - PTR_W'(1);
	end

	assign issue.long_slot  = SLOT_W'(long_q - PTR_W'(1));
	assign issue.short_slot = SLOT_W'(short_q - PTR_W'(1));
	assign issue.weyl_next  = weyl_q + GOLDEN_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= PTR_W'(LONG_LAG);
			short_q <= PTR_W'(SHORT_LAG);
			weyl_q  <= '0;
		end else if (fire) begin
			unique case (act)
				ACT_GEN: begin
					long_q  <= long_dn;
					short_q <= short_dn;
					weyl_q  <= issue.weyl_next;
				end
				ACT_WEYL: begin
					long_q  <= PTR_W'(LONG_LAG);
					short_q <= PTR_W'(SHORT_LAG);
					weyl_q  <= load_value;
				end
				ACT_LOAD, ACT_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lagged_fibonacci_weyl_prng.sv]
// ----------------------------------------------------------------------------
// lagged_fibonacci_weyl_prng
// Additive lagged Fibonacci generator (lags 607, 273) modulo 2^64 whitened
// by a Weyl sequence, with the lag ring held in a two-read-port memory.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   action, entry_index, load_value
//   rsp      out  valid/ready   random_word
//
// One request per cycle while req.ready is high. A generate request reads
// the ring in the cycle it is taken, adds and writes back in stage 1 once
// the output has room, and shows its word on rsp. The write-back is
// forwarded to the following request's reads. Reset sets the pointers to
// their lags and clears the Weyl counter and valid flags; ring contents
// stay undefined until loaded. A stalled rsp holds the word; req.ready
// drops only while a finished word waits and the next generate has no room.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_fibonacci_weyl_prng (
	input wire logic clk,
	input wire logic arst_n,
	lfw_req_if.sink  req,
	lfw_rsp_if.source rsp
);
	import lfw_pkg::*;

	issue_t            issue;
	action_t           act;
	logic              fire;
	logic              ld_ok;
	logic              adv;

	logic              v_s1;
	logic              gen_s1;
	logic [SLOT_W-1:0] slot_a_s1;
	logic [SLOT_W-1:0] slot_b_s1;
	logic [WORD_W-1:0] data_s1;

	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;
	logic [WORD_W-1:0] opa;
	logic [WORD_W-1:0] opb;
	logic [WORD_W-1:0] sum;

	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	logic              fwd_v_q;
	logic [SLOT_W-1:0] fwd_slot_q;
	logic [WORD_W-1:0] fwd_data_q;

	logic              out_v_q;
	logic [WORD_W-1:0] out_word_q;

	assign act   = action_t'(req.action);
	assign adv   = !v_s1 || !gen_s1 || !out_v_q || rsp.ready;
	assign fire  = req.valid && adv;
	assign ld_ok = (req.entry_index != '0) && (req.entry_index <= PTR_W'(LONG_LAG));

	assign req.ready       = adv;
	assign rsp.valid       = out_v_q;
	assign rsp.random_word = out_word_q;

	lfw_ptr u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.action     (req.action),
		.load_value (req.load_value),
		.issue      (issue)
	);

	lfw_ring u_ring (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_slot   (slot_a_s1),
		.wr_data   (wr_data),
		.rd_en     (fire && (act == ACT_GEN)),
		.rd_a_slot (issue.long_slot),
		.rd_b_slot (issue.short_slot),
		.rd_a_data (rd_a),
		.rd_b_data (rd_b)
	);

	// stage 1: forward last write, add, write back
	always_comb begin
		opa     = (fwd_v_q && (fwd_slot_q == slot_a_s1)) ? fwd_data_q : rd_a;
		opb     = (fwd_v_q && (fwd_slot_q == slot_b_s1)) ? fwd_data_q : rd_b;
		sum     = opa + opb;
		wr_en   = v_s1 && adv;
		wr_data = gen_s1 ? sum : data_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			gen_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= fire && ((act == ACT_GEN) || ((act == ACT_LOAD) && ld_ok));
			gen_s1 <= act == ACT_GEN;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (act == ACT_GEN) begin
				slot_a_s1 <= issue.long_slot;
				slot_b_s1 <= issue.short_slot;
				data_s1   <= issue.weyl_next;
			end else begin
				slot_a_s1 <= SLOT_W'(req.entry_index - PTR_W'(1));
				slot_b_s1 <= issue.short_slot;
				data_s1   <= req.load_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_slot_q <= slot_a_s1;
			fwd_data_q <= wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (wr_en && gen_s1) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && gen_s1) begin
			out_word_q <= sum ^ data_s1;
		end
	end

	a_hold_only_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |-> (out_v_q && !rsp.ready))
		else $error("stage 1 held without a stalled output");

	a_gen_enters_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (act == ACT_GEN)) |=> (v_s1 && gen_s1))
		else $error("generate request lost before stage 1");

	a_gen_gives_word : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && gen_s1 && adv) |=> out_v_q)
		else $error("generate left stage 1 without a result");

	a_slot_range : assert property (@(posedge clk) disable iff (!arst_n)
		fwd_v_q |-> (fwd_slot_q < SLOT_W'(LONG_LAG)))
		else $error("ring write outside the lag ring");

endmodule

`default_nettype wire
